### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the chroma power curve RTL. The bodies are empty
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in every cycle in which ante holds.
`define CPC_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("cpc assertion failed");

// Check that cond never holds.
`define CPC_ASSERT_NEVER(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
    else $error("cpc assertion failed");

`else

`define CPC_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define CPC_ASSERT_NEVER(lbl, clk_s, rst_s, cond)

`endif

`endif

### src/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg
// Widths, register codes and constant curve tables of the chroma power curve.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int SMP_W   = 8;   // sample width
  localparam int EXP_W   = 9;   // exponent register width, Q8
  localparam int DLOG_W  = 43;  // log2 difference, Q40, up to 7.0
  localparam int FRAC_W  = 40;  // fraction bits of the scaled log
  localparam int AI_W    = 4;   // integer part of the scaled log, up to 13
  localparam int X_W     = 45;  // power value, Q44, up to 1.0
  localparam int T_W     = 32;  // small correction factors
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CB_EXP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CR_EXP = 2'd1;

  // Exponent 1.0, identity curve
  localparam logic [EXP_W-1:0] EXP_RESET = 9'd256;

  // ln2 in Q24
  localparam logic [23:0] LN2_Q24 = 24'd11629080;

  typedef struct packed {
    logic [EXP_W-1:0] cb;
    logic [EXP_W-1:0] cr;
  } exp_pair_t;

  typedef logic [DLOG_W-1:0] dlog_tbl_t [256];
  typedef logic [X_W-1:0]    xhi_tbl_t  [256];
  typedef logic [T_W-1:0]    tlo_tbl_t  [256];

  // log2 of 1..255 in Q40: leading one, then 40 squaring steps on a Q62 mantissa
  function automatic logic [DLOG_W-1:0] log2_q40(input int unsigned m);
    int unsigned n;
    logic [63:0] z;
    logic [127:0] sq;
    logic [FRAC_W-1:0] bits;
    n = 0;
    while (n < 8 && (m >> (n + 1)) != 0) n++;
    z = 64'(m) << (62 - n);
    bits = '0;
    for (int i = 0; i < FRAC_W; i++) begin
      sq = {64'b0, z} * {64'b0, z};
      z  = sq[125:62];
      if (z[63]) begin
        z = z >> 1;
        bits[FRAC_W-1-i] = 1'b1;
      end
    end
    return {3'(n), bits};
  endfunction

  // log2(d) - log2(m) per input code; zero for the center and full-scale codes
  function automatic dlog_tbl_t gen_dlog_tbl();
    dlog_tbl_t t;
    logic [DLOG_W-1:0] l128;
    logic [DLOG_W-1:0] l127;
    l128 = log2_q40(128);
    l127 = log2_q40(127);
    for (int x = 0; x < 256; x++) begin
      if (x == 0 || x == 128 || x == 255) begin
        t[x] = '0;
      end else if (x < 128) begin
        t[x] = l128 - log2_q40(128 - x);
      end else begin
        t[x] = l127 - log2_q40(x - 128);
      end
    end
    return t;
  endfunction

  // 2^-(k/2^8) in Q44
  function automatic xhi_tbl_t gen_xhi_tbl();
    xhi_tbl_t t;
    real r;
    for (int k = 0; k < 256; k++) begin
      r    = $pow(2.0, -real'(k) / 256.0);
      t[k] = X_W'(longint'(r * 17592186044416.0));
    end
    return t;
  endfunction

  // 1 - 2^-(k/2^16) in Q40
  function automatic tlo_tbl_t gen_t2_tbl();
    tlo_tbl_t t;
    real r;
    for (int k = 0; k < 256; k++) begin
      r    = 1.0 - $pow(2.0, -real'(k) / 65536.0);
      t[k] = T_W'(longint'(r * 1099511627776.0));
    end
    return t;
  endfunction

  // 1 - 2^-(k/2^24) in Q48
  function automatic tlo_tbl_t gen_t3_tbl();
    tlo_tbl_t t;
    real r;
    for (int k = 0; k < 256; k++) begin
      r    = 1.0 - $pow(2.0, -real'(k) / 16777216.0);
      t[k] = T_W'(longint'(r * 281474976710656.0));
    end
    return t;
  endfunction

  localparam dlog_tbl_t DLOG_TBL = gen_dlog_tbl();
  localparam xhi_tbl_t  XHI_TBL  = gen_xhi_tbl();
  localparam tlo_tbl_t  T2_TBL   = gen_t2_tbl();
  localparam tlo_tbl_t  T3_TBL   = gen_t3_tbl();

endpackage

### src/cpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// cpc_cfg_regs
// Exponent registers of the Cb and Cr curves, written by index.
// ----------------------------------------------------------------------------
module cpc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]  wr_idx,
  input  logic [cpc_pkg::EXP_W-1:0]      wr_data,
  output cpc_pkg::exp_pair_t             exps
);
  import cpc_pkg::*;

  exp_pair_t exps_r;
  exp_pair_t exps_nxt;

  // Decode the write; drop writes to unknown indexes
  always_comb begin
    exps_nxt = exps_r;
    if (wr_en) begin
      case (wr_idx)
        CFG_CB_EXP: exps_nxt.cb = wr_data;
        CFG_CR_EXP: exps_nxt.cr = wr_data;
        default:    exps_nxt = exps_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exps_r.cb <= EXP_RESET;
      exps_r.cr <= EXP_RESET;
    end else begin
      exps_r <= exps_nxt;
    end
  end

  assign exps = exps_r;

endmodule

### src/cpc_lane.sv
// ----------------------------------------------------------------------------
// cpc_lane
// Seven-stage power curve datapath for one chroma channel: log lookup, scale
// by exponent, exp2 by table product, rescale and round about the center.
// ----------------------------------------------------------------------------
module cpc_lane (
  input  logic                       clk,
  input  logic [cpc_pkg::SMP_W-1:0]  smp_in,
  input  logic [cpc_pkg::EXP_W-1:0]  exp_in,
  output logic [cpc_pkg::SMP_W-1:0]  smp_out
);
  import cpc_pkg::*;

  // Side information carried along the pipe
  typedef struct packed {
    logic neg;   // sample below the center
    logic zero;  // sample at the center with a nonzero exponent, zero result
  } flags_t;

  // Stage 1: log difference lookup
  logic [DLOG_W-1:0] dlog_r, dlog_nxt;
  logic [EXP_W-1:0]  exp_r, exp_nxt;
  flags_t            f1_r, f1_nxt;

  // Stage 2: scaled log
  logic [AI_W-1:0]   ai2_r, ai2_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  flags_t            f2_r, f2_nxt;

  // Stage 3: table factors
  logic [X_W-1:0]    x0_r, x0_nxt;
  logic [T_W-1:0]    t2_r, t2_nxt;
  logic [T_W-1:0]    t3a_r, t3a_nxt;
  logic [T_W-1:0]    t4a_r, t4a_nxt;
  logic [AI_W-1:0]   ai3_r, ai3_nxt;
  flags_t            f3_r, f3_nxt;

  // Stage 4: first correction
  logic [X_W-1:0]    x1_r, x1_nxt;
  logic [T_W-1:0]    t3b_r, t3b_nxt;
  logic [T_W-1:0]    t4b_r, t4b_nxt;
  logic [AI_W-1:0]   ai4_r, ai4_nxt;
  flags_t            f4_r, f4_nxt;

  // Stage 5: second correction
  logic [X_W-1:0]    x2_r, x2_nxt;
  logic [T_W-1:0]    t4c_r, t4c_nxt;
  logic [AI_W-1:0]   ai5_r, ai5_nxt;
  flags_t            f5_r, f5_nxt;

  // Stage 6: last correction
  logic [X_W-1:0]    x3_r, x3_nxt;
  logic [AI_W-1:0]   ai6_r, ai6_nxt;
  flags_t            f6_r, f6_nxt;

  // Stage 7: output sample
  logic [SMP_W-1:0]  out_r, out_nxt;

  logic [DLOG_W+EXP_W-1:0] a_prod;
  logic [39:0]             t4_prod;
  logic [64:0]             m2_prod;
  logic [56:0]             m3_prod;
  logic [48:0]             m4_prod;
  logic [X_W+SMP_W-1:0]    q_prod;
  logic [SMP_W-1:0]        d_sel;
  logic [9:0]              q_hi;
  logic [9:0]              q_sh;
  logic [9:0]              q_rnd;
  logic [SMP_W-1:0]        y_mag;

  // Look up the log difference and classify the sample
  always_comb begin
    dlog_nxt     = DLOG_TBL[smp_in];
    exp_nxt      = exp_in;
    f1_nxt.neg   = ~smp_in[SMP_W-1];
    f1_nxt.zero  = (smp_in == 8'd128) && (exp_in != '0);
  end

  // Scale the log by the exponent, Q8, truncate
  always_comb begin
    a_prod   = DLOG_W'(dlog_r) * exp_r;
    ai2_nxt  = a_prod[DLOG_W+EXP_W-1 -: AI_W];
    frac_nxt = a_prod[FRAC_W+7:8];
    f2_nxt   = f1_r;
  end

  // Split the fraction into table factors and a linear tail
  always_comb begin
    x0_nxt  = XHI_TBL[frac_r[39:32]];
    t2_nxt  = T2_TBL[frac_r[31:24]];
    t3a_nxt = T3_TBL[frac_r[23:16]];
    t4_prod = frac_r[15:0] * LN2_Q24;
    t4a_nxt = t4_prod[39:8];
    ai3_nxt = ai2_r;
    f3_nxt  = f2_r;
  end

  // Apply 1 - t2: x * t2 with x in Q32 and t2 in Q40
  always_comb begin
    m2_prod = x0_r[X_W-1:12] * t2_r;
    x1_nxt  = x0_r - X_W'(m2_prod[64:28]);
    t3b_nxt = t3a_r;
    t4b_nxt = t4a_r;
    ai4_nxt = ai3_r;
    f4_nxt  = f3_r;
  end

  // Apply 1 - t3: x in Q24, t3 in Q48
  always_comb begin
    m3_prod = x1_r[X_W-1:20] * t3b_r;
    x2_nxt  = x1_r - X_W'(m3_prod[56:28]);
    t4c_nxt = t4b_r;
    ai5_nxt = ai4_r;
    f5_nxt  = f4_r;
  end

  // Apply 1 - t4: x in Q16, t4 in Q56
  always_comb begin
    m4_prod = x2_r[X_W-1:28] * t4c_r;
    x3_nxt  = x2_r - X_W'(m4_prod[48:28]);
    ai6_nxt = ai5_r;
    f6_nxt  = f5_r;
  end

  // Form floor(2*d*p), shift by the integer part, round half up, fold about 128
  always_comb begin
    d_sel  = f6_r.neg ? 8'd128 : 8'd127;
    q_prod = x3_r * d_sel;
    q_hi   = q_prod[X_W+SMP_W-1:X_W-2];
    q_sh   = q_hi >> ai6_r;
    q_rnd  = q_sh + 10'd1;
    y_mag  = f6_r.zero ? 8'd0 : q_rnd[SMP_W:1];
    out_nxt = f6_r.neg ? (8'd128 - y_mag) : (8'd128 + y_mag);
  end

  // Advance every stage each cycle; the valid chain lives in the top level
  always_ff @(posedge clk) begin
    dlog_r <= dlog_nxt;
    exp_r  <= exp_nxt;
    f1_r   <= f1_nxt;
    ai2_r  <= ai2_nxt;
    frac_r <= frac_nxt;
    f2_r   <= f2_nxt;
    x0_r   <= x0_nxt;
    t2_r   <= t2_nxt;
    t3a_r  <= t3a_nxt;
    t4a_r  <= t4a_nxt;
    ai3_r  <= ai3_nxt;
    f3_r   <= f3_nxt;
    x1_r   <= x1_nxt;
    t3b_r  <= t3b_nxt;
    t4b_r  <= t4b_nxt;
    ai4_r  <= ai4_nxt;
    f4_r   <= f4_nxt;
    x2_r   <= x2_nxt;
    t4c_r  <= t4c_nxt;
    ai5_r  <= ai5_nxt;
    f5_r   <= f5_nxt;
    x3_r   <= x3_nxt;
    ai6_r  <= ai6_nxt;
    f6_r   <= f6_nxt;
    out_r  <= out_nxt;
  end

  assign smp_out = out_r;

endmodule

### src/chroma_power_curve.sv
// ----------------------------------------------------------------------------
// chroma_power_curve
// Maps each Cb/Cr sample pair through a power curve symmetric about 128,
// with one exponent register per channel.
//
//   channel   handshake            payload
//   input     start / busy         in_cb_in, in_cr_in
//   result    out_valid (strobe)   out_cb_out, out_cr_out
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per clock; each result passes through the seven register stages
// of each channel datapath.
// busy stays low and cfg_ready stays high.
// Reset sets both exponents to 1.0 and clears the valid chain.
// The receiver cannot stall; results leave on the out_valid strobe.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chroma_power_curve (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cpc_pkg::SMP_W-1:0]     in_cb_in,
  input  logic [cpc_pkg::SMP_W-1:0]     in_cr_in,
  output logic                          out_valid,
  output logic [cpc_pkg::SMP_W-1:0]     out_cb_out,
  output logic [cpc_pkg::SMP_W-1:0]     out_cr_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpc_pkg::EXP_W-1:0]     cfg_data
);
  import cpc_pkg::*;

  localparam int LAT = 7;

  exp_pair_t      exps;
  logic           accept;
  logic [LAT-1:0] vld_r, vld_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // Exponent registers
  cpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid & cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .exps    (exps)
  );

  // Channel datapaths
  cpc_lane u_cb (
    .clk     (clk),
    .smp_in  (in_cb_in),
    .exp_in  (exps.cb),
    .smp_out (out_cb_out)
  );

  cpc_lane u_cr (
    .clk     (clk),
    .smp_in  (in_cr_in),
    .exp_in  (exps.cr),
    .smp_out (out_cr_out)
  );

  // Shift the valid bit alongside the datapath stages
  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[LAT-1];

  `CPC_ASSERT_NEVER(a_no_spurious_out, clk, rst_n, out_valid && !$past(accept, LAT))
  `CPC_ASSERT_IMPL(a_cb_low_side, clk, rst_n, out_valid && ($past(in_cb_in, LAT) < 8'd128), out_cb_out <= 8'd128)
  `CPC_ASSERT_IMPL(a_cr_high_side, clk, rst_n, out_valid && ($past(in_cr_in, LAT) >= 8'd128), out_cr_out >= 8'd128)
  `CPC_ASSERT_IMPL(a_cb_full_scale, clk, rst_n, out_valid && ($past(in_cb_in, LAT) == 8'd255), out_cb_out == 8'd255)

endmodule
